>>> src/ttsd_pkg.sv
`default_nettype none
package ttsd_pkg;

    // File format constants
    localparam logic [31:0] MAGIC        = 32'h5453_4433;
    localparam logic [31:0] VERSION      = 32'd3;
    localparam logic [31:0] IMG_WIDTH    = 32'd64;
    localparam logic [31:0] HEIGHT_SMALL = 32'd32;
    localparam int          HEADER_WORDS = 8;

    // Field widths
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 13;
    localparam int HEIGHT_W = 7;
    localparam int INDEX_W  = 12;
    localparam int STATUS_W = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Header word positions
    localparam logic [COUNT_W-1:0] POS_MAGIC   = COUNT_W'(0);
    localparam logic [COUNT_W-1:0] POS_VERSION = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] POS_WIDTH   = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] POS_HEIGHT  = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] POS_PIXELS  = COUNT_W'(HEADER_WORDS);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_MAGIC  = 3'd1,
        ST_BAD_VER    = 3'd2,
        ST_BAD_SIZE   = 3'd3,
        ST_BAD_LENGTH = 3'd4
    } t_status;

    typedef struct packed {
        logic                pixel_valid;
        logic [INDEX_W-1:0]  pixel_index;
        logic [WORD_W-1:0]   pixel_rgba;
        logic                done_res;
        t_status             status;
    } t_result;

    // Reverse byte order so red lands in bits 7:0
    function automatic logic [WORD_W-1:0] byte_swap(input logic [WORD_W-1:0] w);
        byte_swap = {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage
`default_nettype wire

>>> src/ttsd_if.sv
`default_nettype none
// Input channel: one file word per beat
interface ttsd_in_if;
    logic                        valid;
    logic                        ready;
    logic [ttsd_pkg::WORD_W-1:0] file_word;
    logic                        last;

    modport source (output valid, output file_word, output last, input ready);
    modport sink   (input valid, input file_word, input last, output ready);
endinterface

// Output channel: one result per input beat
interface ttsd_out_if;
    logic                          valid;
    logic                          ready;
    logic                          pixel_valid;
    logic [ttsd_pkg::INDEX_W-1:0]  pixel_index;
    logic [ttsd_pkg::WORD_W-1:0]   pixel_rgba;
    logic                          done_res;
    logic [ttsd_pkg::STATUS_W-1:0] status;

    modport source (output valid, output pixel_valid, output pixel_index,
                    output pixel_rgba, output done_res, output status, input ready);
    modport sink   (input valid, input pixel_valid, input pixel_index,
                    input pixel_rgba, input done_res, input status, output ready);
endinterface
`default_nettype wire

>>> src/ttsd_detile.sv
`default_nettype none
// Maps a tiled pixel number to its linear destination index:
// undoes the 8x8 Morton interleave and flips the rows.
module ttsd_detile (
    input  wire logic [ttsd_pkg::INDEX_W-1:0]  i_pixel_num,
    input  wire logic [ttsd_pkg::HEIGHT_W-1:0] i_height,
    output logic      [ttsd_pkg::INDEX_W-1:0]  o_index
);
    logic [2:0] xl;
    logic [2:0] yl;
    logic [5:0] x;
    logic [5:0] gy;
    logic [5:0] y;

    // De-interleave within the tile, then place the tile
    always_comb begin
        xl = {i_pixel_num[4], i_pixel_num[2], i_pixel_num[0]};
        yl = {i_pixel_num[5], i_pixel_num[3], i_pixel_num[1]};
        x  = {i_pixel_num[8:6], xl};
        gy = {i_pixel_num[11:9], yl};
        // row flip, modulo 64
        y  = i_height[5:0] - 6'd1 - gy;
        o_index = {y, x};
    end
endmodule
`default_nettype wire

>>> src/tiled_texture_stream_decode_unit.sv
`default_nettype none
// Tiled texture stream decoder. Takes a texture file one 32-bit little-endian word
// per beat, checks the eight-word header (magic, version 3, width 64, height 32 or
// 64) and turns every following word into one result carrying the linear pixel
// index (row * 64 + column) and the byte-reversed pixel. Every input beat gives
// exactly one result beat, in the next cycle; a new word is taken every cycle, the
// only limit being the single result register, which frees as the consumer takes
// it. Errors are sticky and stop further pixels; status on the result for the word
// marked last reports a wrong total length, and the pixel on that word is still
// given, so the consumer drops the image whenever the final status is non-zero.
// Counter, height and error return to zero after the last word.
module tiled_texture_stream_decode_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ttsd_in_if.sink     i_in,
    ttsd_out_if.source  o_out
);
    localparam int CW = ttsd_pkg::COUNT_W;
    localparam int HW = ttsd_pkg::HEIGHT_W;

    logic [CW-1:0]       r_word_count, n_word_count;
    logic [HW-1:0]       r_height, n_height;
    ttsd_pkg::t_status   r_err, n_err;
    logic                r_out_valid;
    ttsd_pkg::t_result   r_res, n_res;

    logic                accept;
    ttsd_pkg::t_status   hdr_code;
    ttsd_pkg::t_status   err_mid;
    logic [CW-1:0]       pix_num;
    logic [CW-1:0]       pix_limit;
    logic [CW-1:0]       count_inc;
    logic                is_pixel;
    logic [ttsd_pkg::INDEX_W-1:0] det_index;

    // Handshake: result register frees when it is empty or being taken
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    ttsd_detile u_detile (
        .i_pixel_num (pix_num[ttsd_pkg::INDEX_W-1:0]),
        .i_height    (r_height),
        .o_index     (det_index)
    );

    // Per-word decode
    always_comb begin
        hdr_code = ttsd_pkg::ST_OK;
        n_height = r_height;
        priority if (r_word_count == ttsd_pkg::POS_MAGIC) begin
            if (i_in.file_word != ttsd_pkg::MAGIC) hdr_code = ttsd_pkg::ST_BAD_MAGIC;
        end else if (r_word_count == ttsd_pkg::POS_VERSION) begin
            if (i_in.file_word != ttsd_pkg::VERSION) hdr_code = ttsd_pkg::ST_BAD_VER;
        end else if (r_word_count == ttsd_pkg::POS_WIDTH) begin
            if (i_in.file_word != ttsd_pkg::IMG_WIDTH) hdr_code = ttsd_pkg::ST_BAD_SIZE;
        end else if (r_word_count == ttsd_pkg::POS_HEIGHT) begin
            if (i_in.file_word == ttsd_pkg::HEIGHT_SMALL ||
                i_in.file_word == ttsd_pkg::IMG_WIDTH) begin
                n_height = i_in.file_word[HW-1:0];
            end else begin
                hdr_code = ttsd_pkg::ST_BAD_SIZE;
            end
        end else begin
            hdr_code = ttsd_pkg::ST_OK;
        end

        // pixel number and limit 64 * height
        pix_num   = r_word_count - ttsd_pkg::POS_PIXELS;
        pix_limit = {r_height, 6'd0};
        is_pixel  = (r_word_count >= ttsd_pkg::POS_PIXELS) &&
                    (r_err == ttsd_pkg::ST_OK) && (pix_num < pix_limit);

        // saturating word counter
        count_inc = (r_word_count < ttsd_pkg::COUNT_MAX) ? r_word_count + 1'b1
                                                          : r_word_count;

        // first error wins
        err_mid = (r_err != ttsd_pkg::ST_OK) ? r_err : hdr_code;
        n_err   = err_mid;
        if (i_in.last && err_mid == ttsd_pkg::ST_OK &&
            count_inc != ttsd_pkg::POS_PIXELS + {n_height, 6'd0}) begin
            n_err = ttsd_pkg::ST_BAD_LENGTH;
        end

        n_res.pixel_valid = is_pixel;
        n_res.pixel_index = is_pixel ? det_index : '0;
        n_res.pixel_rgba  = is_pixel ? ttsd_pkg::byte_swap(i_in.file_word) : '0;
        n_res.done_res    = i_in.last;
        n_res.status      = n_err;

        n_word_count = count_inc;
    end

    // File state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_count <= '0;
            r_height     <= '0;
            r_err        <= ttsd_pkg::ST_OK;
        end else if (accept) begin
            if (i_in.last) begin
                r_word_count <= '0;
                r_height     <= '0;
                r_err        <= ttsd_pkg::ST_OK;
            end else begin
                r_word_count <= n_word_count;
                r_height     <= n_height;
                r_err        <= n_err;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.pixel_valid = r_res.pixel_valid;
    assign o_out.pixel_index = r_res.pixel_index;
    assign o_out.pixel_rgba  = r_res.pixel_rgba;
    assign o_out.done_res    = r_res.done_res;
    assign o_out.status      = r_res.status;

    // A pixel only goes out with a clean status, or a length error on the last beat
    a_pixel_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.pixel_valid |->
            (r_res.status == ttsd_pkg::ST_OK) ||
            (r_res.done_res && r_res.status == ttsd_pkg::ST_BAD_LENGTH))
        else $error("pixel emitted under an error status");

    // State clears after the last beat of a file
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.last |=>
            r_word_count == '0 && r_height == '0 && r_err == ttsd_pkg::ST_OK)
        else $error("file state not cleared after last beat");

    // Errors are sticky within a file
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_in.last && r_err != ttsd_pkg::ST_OK |=> r_err == $past(r_err))
        else $error("sticky error changed");

    // Height is only ever unset, 32 or 64
    a_height_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_height == '0 || r_height == HW'(32) || r_height == HW'(64))
        else $error("illegal image height held");

endmodule
`default_nettype wire
